// ===== src/assert_macros.svh =====
// Assertion macros used by the menu controller back (bmsc_back).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted (active-low reset).
`define BMSC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define BMSC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/bmsc_pkg.sv =====
// Package: event codes, menu states and settings table of the menu controller.
package bmsc_pkg;

    // Default sizes of the menu.
    localparam int SCREEN_COUNT_DEF  = 4;
    localparam int SETTING_COUNT_DEF = 9;
    localparam int STORE_DEPTH       = 9;

    // Request kinds carried on tuser.
    localparam logic [2:0] REQ_SHORT      = 3'd0;
    localparam logic [2:0] REQ_LONG       = 3'd1;
    localparam logic [2:0] REQ_NEXT_SCR   = 3'd2;
    localparam logic [2:0] REQ_PREV_SCR   = 3'd3;
    localparam logic [2:0] REQ_NEXT_COLOR = 3'd4;

    // Event sources carried on tdata.
    localparam logic [1:0] SRC_RIGHT = 2'd0;
    localparam logic [1:0] SRC_LEFT  = 2'd1;
    localparam logic [1:0] SRC_TOP   = 2'd2;
    localparam logic [1:0] SRC_DEMO  = 2'd3;

    // Last palette index before wrapping to zero.
    localparam logic [7:0] PALETTE_LAST = 8'd254;

    // Classified events handed from the front to the back.
    typedef enum logic [3:0] {
        EVT_NONE,
        EVT_R_SHORT,
        EVT_R_LONG,
        EVT_L_SHORT,
        EVT_L_LONG,
        EVT_T_SHORT,
        EVT_T_LONG,
        EVT_D_NEXT,
        EVT_D_PREV,
        EVT_D_COLOR
    } evt_t;

    // Menu states: normal mode, settings idle, settings edit.
    typedef enum logic [1:0] {
        MODE_HOME,
        MODE_IDLE,
        MODE_EDIT
    } mode_t;

    // Head of the event queue as seen by the back.
    typedef struct packed {
        logic valid;
        evt_t evt;
    } evq_out_t;

    // Settings table: minimum, maximum and step of each entry.
    localparam logic [7:0] SET_MIN [STORE_DEPTH] =
        '{8'd0, 8'd5, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
    localparam logic [7:0] SET_MAX [STORE_DEPTH] =
        '{8'd1, 8'd255, 8'd255, 8'd23, 8'd23, 8'd1, 8'd1, 8'd1, 8'd2};
    localparam logic [7:0] SET_STEP [STORE_DEPTH] =
        '{8'd1, 8'd5, 8'd5, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1};

    // Increment: saturate at max, wrap to min when already at max.
    function automatic logic [7:0] step_up(input logic [7:0] v, input logic [3:0] k);
        logic [8:0] sum;
        logic [7:0] res;
        sum = {1'b0, v} + {1'b0, SET_STEP[k]};
        if (v < SET_MAX[k]) begin
            res = (sum > {1'b0, SET_MAX[k]}) ? SET_MAX[k] : sum[7:0];
        end else begin
            res = SET_MIN[k];
        end
        return res;
    endfunction

    // Decrement: saturate at min, wrap to max when already at min.
    function automatic logic [7:0] step_down(input logic [7:0] v, input logic [3:0] k);
        logic [8:0] floor_v;
        logic [7:0] res;
        floor_v = {1'b0, SET_MIN[k]} + {1'b0, SET_STEP[k]};
        if (v > SET_MIN[k]) begin
            res = ({1'b0, v} < floor_v) ? SET_MIN[k] : (v - SET_STEP[k]);
        end else begin
            res = SET_MAX[k];
        end
        return res;
    endfunction

endpackage

// ===== src/bmsc_front.sv =====
// Front: accepts input transactions and classifies them into menu events.
module bmsc_front
    import bmsc_pkg::*;
(
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [1:0] event_source
    input  logic [2:0] s_tuser,   // [2:0] req_type
    input  logic       q_full,
    output logic       q_push,
    output evt_t       q_evt
);

    logic [1:0] source;
    logic [2:0] kind;

    assign source   = s_tdata[1:0];
    assign kind     = s_tuser;
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    // Classify the (kind, source) pair; unsupported pairs become no-op events.
    always_comb begin
        q_evt = EVT_NONE;
        unique case (source)
            SRC_RIGHT: begin
                if (kind == REQ_SHORT)     q_evt = EVT_R_SHORT;
                else if (kind == REQ_LONG) q_evt = EVT_R_LONG;
            end
            SRC_LEFT: begin
                if (kind == REQ_SHORT)     q_evt = EVT_L_SHORT;
                else if (kind == REQ_LONG) q_evt = EVT_L_LONG;
            end
            SRC_TOP: begin
                if (kind == REQ_SHORT)     q_evt = EVT_T_SHORT;
                else if (kind == REQ_LONG) q_evt = EVT_T_LONG;
            end
            SRC_DEMO: begin
                if (kind == REQ_NEXT_SCR)        q_evt = EVT_D_NEXT;
                else if (kind == REQ_PREV_SCR)   q_evt = EVT_D_PREV;
                else if (kind == REQ_NEXT_COLOR) q_evt = EVT_D_COLOR;
            end
            default: q_evt = EVT_NONE;
        endcase
    end

endmodule

// ===== src/bmsc_queue.sv =====
// Two-entry event queue between the front and the back.
module bmsc_queue
    import bmsc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  evt_t     push_evt,
    output logic     full,
    input  logic     pop,
    output evq_out_t head
);

    evt_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign full       = (count_reg == 2'd2);
    assign do_push    = push && !full;
    assign do_pop     = pop && (count_reg != 2'd0);
    assign head.valid = (count_reg != 2'd0);
    assign head.evt   = entry_reg[rd_ptr_reg];

    // Advance pointers and occupancy.
    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed event.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_evt;
        end
    end

endmodule

// ===== src/bmsc_back.sv =====
// Back: menu state machine, settings store and registered result output.
`include "assert_macros.svh"
module bmsc_back
    import bmsc_pkg::*;
#(
    parameter int SCREEN_COUNT  = SCREEN_COUNT_DEF,
    parameter int SETTING_COUNT = SETTING_COUNT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  evq_out_t    q_head,
    output logic        q_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata
);

    localparam logic [3:0] SCREEN_LAST = 4'(SCREEN_COUNT - 1);
    localparam logic [3:0] SEL_LAST    = 4'(SETTING_COUNT - 1);

    mode_t       mode_reg, mode_next;
    logic [3:0]  screen_reg, screen_next;
    logic [3:0]  sel_reg, sel_next;
    logic [7:0]  palette_reg, palette_next;
    logic [7:0]  store_reg [STORE_DEPTH];
    logic        m_tvalid_reg, m_tvalid_next;
    logic [31:0] m_tdata_reg, m_tdata_next;

    logic        fire;
    logic        hit;
    logic        bump_up;
    logic        bump_down;
    logic [7:0]  rd_val;
    logic [7:0]  value_now;

    // Take the next event whenever the output register is free or draining.
    assign fire  = q_head.valid && (!m_tvalid_reg || m_tready);
    assign q_pop = fire;

    // Next menu state.
    always_comb begin
        mode_next = mode_reg;
        if (fire) begin
            unique case (mode_reg)
                MODE_HOME: begin
                    if (q_head.evt == EVT_T_LONG) mode_next = MODE_IDLE;
                end
                MODE_IDLE: begin
                    if (q_head.evt == EVT_T_SHORT)     mode_next = MODE_EDIT;
                    else if (q_head.evt == EVT_T_LONG) mode_next = MODE_HOME;
                end
                MODE_EDIT: begin
                    if (q_head.evt == EVT_T_SHORT || q_head.evt == EVT_T_LONG) begin
                        mode_next = MODE_IDLE;
                    end
                end
                default: mode_next = MODE_HOME;
            endcase
        end
    end

    // Per-state actions on screen, palette, selection and the store.
    always_comb begin
        screen_next  = screen_reg;
        sel_next     = sel_reg;
        palette_next = palette_reg;
        bump_up      = 1'b0;
        bump_down    = 1'b0;
        hit          = 1'b1;
        unique case (mode_reg)
            MODE_HOME: begin
                case (q_head.evt) inside
                    EVT_R_SHORT, EVT_R_LONG, EVT_D_NEXT:
                        screen_next = (screen_reg == SCREEN_LAST) ? 4'd0 : screen_reg + 4'd1;
                    EVT_L_SHORT, EVT_L_LONG, EVT_D_PREV:
                        screen_next = (screen_reg == 4'd0) ? SCREEN_LAST : screen_reg - 4'd1;
                    EVT_T_SHORT, EVT_D_COLOR:
                        palette_next = (palette_reg == PALETTE_LAST) ? 8'd0
                                                                     : palette_reg + 8'd1;
                    EVT_T_LONG: hit = 1'b1;
                    default:    hit = 1'b0;
                endcase
            end
            MODE_IDLE: begin
                case (q_head.evt) inside
                    EVT_R_SHORT: sel_next = (sel_reg == SEL_LAST) ? 4'd0 : sel_reg + 4'd1;
                    EVT_L_SHORT: sel_next = (sel_reg == 4'd0) ? SEL_LAST : sel_reg - 4'd1;
                    EVT_T_SHORT, EVT_T_LONG: hit = 1'b1;
                    default:     hit = 1'b0;
                endcase
            end
            MODE_EDIT: begin
                case (q_head.evt) inside
                    EVT_R_SHORT: bump_up   = 1'b1;
                    EVT_L_SHORT: bump_down = 1'b1;
                    EVT_T_SHORT, EVT_T_LONG: hit = 1'b1;
                    default:     hit = 1'b0;
                endcase
            end
            default: hit = 1'b0;
        endcase
    end

    // Read the store at the selection after this event; bumps keep the selection.
    assign rd_val = store_reg[sel_next];

    always_comb begin
        if (bump_up)        value_now = step_up(rd_val, sel_reg);
        else if (bump_down) value_now = step_down(rd_val, sel_reg);
        else                value_now = rd_val;
    end

    // Load the result register when an event fires; drop valid once taken.
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (fire) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {5'd0, hit, palette_next, value_now, sel_next, screen_next,
                             (mode_next == MODE_EDIT), (mode_next != MODE_HOME)};
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_HOME;
            screen_reg   <= 4'd0;
            sel_reg      <= 4'd0;
            palette_reg  <= 8'd0;
            m_tvalid_reg <= 1'b0;
            for (int k = 0; k < STORE_DEPTH; k++) begin
                store_reg[k] <= SET_MIN[k];
            end
        end else begin
            m_tvalid_reg <= m_tvalid_next;
            if (fire) begin
                mode_reg    <= mode_next;
                screen_reg  <= screen_next;
                sel_reg     <= sel_next;
                palette_reg <= palette_next;
                if (bump_up || bump_down) begin
                    store_reg[sel_reg] <= value_now;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `BMSC_ASSERT(a_screen_range, aclk, aresetn, screen_reg <= SCREEN_LAST, "screen out of range")
    `BMSC_ASSERT(a_sel_range, aclk, aresetn, sel_reg <= SEL_LAST, "setting out of range")
    `BMSC_ASSERT(a_pal_range, aclk, aresetn, palette_reg <= PALETTE_LAST, "palette out of range")
    `BMSC_ASSERT(a_hold_on_stall, aclk, aresetn, (m_tvalid && !m_tready) |=> ($stable(mode_reg) && $stable(sel_reg)), "state moved while result stalled")

endmodule

// ===== src/button_menu_settings_controller_unit.sv =====
// Top level of the button menu and settings controller.
//
//  channel | dir | payload
//  s_      | in  | tdata[1:0] event_source, tuser[2:0] req_type
//  m_      | out | tdata[0] in_settings, [1] editing, [5:2] screen_now,
//          |     |   [9:6] setting_now, [17:10] setting_value,
//          |     |   [25:18] palette_now, [26] event_matched
//
// One event per cycle sustained while m_tready takes each result; an accepted input
// transaction is first written into the queue; the back then loads the result
// register from the queue head and raises m_tvalid.
// Reset clears the menu state, the queue and the output valid, and loads each
// setting with its minimum in the same cycle.
// A stalled result holds the back; the two-entry queue keeps s_tready high
// until it fills.
module button_menu_settings_controller_unit
    import bmsc_pkg::*;
#(
    parameter int SCREEN_COUNT  = SCREEN_COUNT_DEF,
    parameter int SETTING_COUNT = SETTING_COUNT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [1:0] event_source
    input  logic [2:0]  s_tuser,   // [2:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // in_settings, editing, screen_now, setting_now,
                                   // setting_value, palette_now, event_matched
);

    logic     q_full;
    logic     q_push;
    evt_t     q_evt;
    logic     q_pop;
    evq_out_t q_head;

    bmsc_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_evt    (q_evt)
    );

    bmsc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_evt (q_evt),
        .full     (q_full),
        .pop      (q_pop),
        .head     (q_head)
    );

    bmsc_back #(
        .SCREEN_COUNT  (SCREEN_COUNT),
        .SETTING_COUNT (SETTING_COUNT)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
